### hw/rtl/lphtu_pkg.sv
// ----------------------------------------------------------------------------
// lphtu_pkg
// shared codes and constants of the linear probing hash table unit
// ----------------------------------------------------------------------------
package lphtu_pkg;

    // slot memory depth and the widths that follow from it
    localparam int TABLE_DEPTH = 64;
    localparam int SLOT_W      = 6;
    localparam int CAP_W       = 7;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [1:0] {
        ACT_SEARCH = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_ERASE  = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        TAG_EMPTY   = 2'd0,
        TAG_USED    = 2'd1,
        TAG_DELETED = 2'd2
    } t_tag;

    typedef enum logic [1:0] {
        REG_CAPACITY = 2'd0,
        REG_NONE     = 2'd1
    } t_reg;

endpackage

### hw/rtl/lphtu_front.sv
// ----------------------------------------------------------------------------
// lphtu_front
// takes items, finds the home slot with a bit-serial remainder unit
// ----------------------------------------------------------------------------
module lphtu_front #(
    parameter int KEY_BITS = 16,
    parameter int SLOT_W   = 6
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  lphtu_pkg::t_action          i_action,
    input  logic [KEY_BITS-1:0]         i_key,
    input  logic [lphtu_pkg::CAP_W-1:0] i_cap,
    input  logic                        i_q_full,
    output logic                        o_push,
    output lphtu_pkg::t_action          o_action,
    output logic [KEY_BITS-1:0]         o_key,
    output logic [SLOT_W-1:0]           o_home,
    output logic                        o_busy
);
    localparam int CNT_W = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
    localparam int CW    = lphtu_pkg::CAP_W;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    t_fstate               r_state, n_state;
    lphtu_pkg::t_action    r_action;
    logic [KEY_BITS-1:0]   r_key, r_shift;
    logic [CW-1:0]         r_rem, n_rem;
    logic [CNT_W-1:0]      r_cnt;
    logic [CW:0]           trial;

    // one quotient bit a cycle
    always_comb begin
        trial = {r_rem, r_shift[KEY_BITS-1]};
        if (trial >= {1'b0, i_cap}) begin
            n_rem = CW'(trial - {1'b0, i_cap});
        end else begin
            n_rem = trial[CW-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (i_accept) begin
                n_state = (i_action == lphtu_pkg::ACT_CLEAR) ? F_PUSH : F_DIV;
            end
            F_DIV:  if (r_cnt == CNT_W'(KEY_BITS - 1)) n_state = F_PUSH;
            F_PUSH: if (!i_q_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (r_state == F_IDLE && i_accept) begin
            r_action <= i_action;
            r_key    <= i_key;
            r_shift  <= i_key;
            r_rem    <= '0;
            r_cnt    <= '0;
        end else if (r_state == F_DIV) begin
            r_rem   <= n_rem;
            r_shift <= r_shift << 1;
            r_cnt   <= r_cnt + 1'b1;
        end
    end

    assign o_push   = (r_state == F_PUSH) && !i_q_full;
    assign o_action = r_action;
    assign o_key    = r_key;
    assign o_home   = SLOT_W'(r_rem);
    assign o_busy   = (r_state != F_IDLE);

endmodule

### hw/rtl/lphtu_queue.sv
// ----------------------------------------------------------------------------
// lphtu_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
module lphtu_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_valid,
    output logic             o_full
);
    logic [WIDTH-1:0] r_buf [2];
    logic             r_wptr, r_rptr;
    logic [1:0]       r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wptr <= ~r_wptr;
            if (i_pop)  r_rptr <= ~r_rptr;
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
        if (i_push) r_buf[r_wptr] <= i_data;
    end

    assign o_data  = r_buf[r_rptr];
    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);

endmodule

### hw/rtl/lphtu_back.sv
// ----------------------------------------------------------------------------
// lphtu_back
// slot memory, probe walk, clearing sweep and result register
// ----------------------------------------------------------------------------
module lphtu_back #(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_BITS    = 16,
    parameter int SLOT_W      = 6
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_clear,
    input  logic [lphtu_pkg::CAP_W-1:0] i_cap,
    input  logic                        i_valid,
    input  lphtu_pkg::t_action          i_action,
    input  logic [KEY_BITS-1:0]         i_key,
    input  logic [SLOT_W-1:0]           i_home,
    output logic                        o_pop,
    output logic                        o_sweeping,
    output logic                        o_done,
    output lphtu_pkg::t_status          o_status,
    output logic [SLOT_W-1:0]           o_slot_index,
    output logic [lphtu_pkg::CAP_W-1:0] o_occupancy
);
    localparam int CW      = lphtu_pkg::CAP_W;
    localparam int ENTRY_W = 2 + KEY_BITS;

    typedef enum logic [3:0] {
        B_SWEEP = 4'b0001,
        B_IDLE  = 4'b0010,
        B_READ  = 4'b0100,
        B_EVAL  = 4'b1000
    } t_bstate;

    logic [ENTRY_W-1:0]  mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0]  r_rdata, wd;
    logic [SLOT_W-1:0]   wa;
    logic                we;

    t_bstate             r_state, n_state;
    lphtu_pkg::t_action  r_action;
    logic [KEY_BITS-1:0] r_key;
    logic [SLOT_W-1:0]   r_pos, n_pos, r_sweep;
    logic [CW-1:0]       r_n, r_used, n_used;
    logic                r_reply;

    logic                n_done;
    lphtu_pkg::t_status  n_status;
    logic [SLOT_W-1:0]   n_slot;

    lphtu_pkg::t_tag     tag;
    logic [KEY_BITS-1:0] rkey;
    logic [SLOT_W:0]     pos_inc;
    logic                last, hit, sweep_end;

    assign tag       = lphtu_pkg::t_tag'(r_rdata[ENTRY_W-1 -: 2]);
    assign rkey      = r_rdata[KEY_BITS-1:0];
    assign pos_inc   = {1'b0, r_pos} + 1'b1;
    assign last      = (({1'b0, r_n} + 1'b1) == {1'b0, i_cap});
    assign hit       = (tag == lphtu_pkg::TAG_USED) && (rkey == r_key);
    assign sweep_end = (r_sweep == SLOT_W'(TABLE_DEPTH - 1));

    always_comb begin
        n_state  = r_state;
        n_used   = r_used;
        n_pos    = (pos_inc == (SLOT_W + 1)'(i_cap)) ? '0 : pos_inc[SLOT_W-1:0];
        n_done   = 1'b0;
        n_status = lphtu_pkg::ST_DONE;
        n_slot   = '0;
        we       = 1'b0;
        wa       = r_pos;
        wd       = {lphtu_pkg::TAG_EMPTY, {KEY_BITS{1'b0}}};
        o_pop    = 1'b0;
        unique case (r_state)
            B_SWEEP: begin
                we = 1'b1;
                wa = r_sweep;
                if (sweep_end) begin
                    n_state = B_IDLE;
                    n_done  = r_reply;
                end
            end
            B_IDLE: if (i_valid) begin
                o_pop = 1'b1;
                if (i_action == lphtu_pkg::ACT_CLEAR) begin
                    n_state = B_SWEEP;
                    n_used  = '0;
                end else begin
                    n_state = B_READ;
                end
            end
            B_READ: n_state = B_EVAL;
            B_EVAL: begin
                if (r_action == lphtu_pkg::ACT_INSERT) begin
                    if (tag != lphtu_pkg::TAG_USED) begin
                        we      = 1'b1;
                        wd      = {lphtu_pkg::TAG_USED, r_key};
                        n_used  = r_used + 1'b1;
                        n_done  = 1'b1;
                        n_slot  = r_pos;
                        n_state = B_IDLE;
                    end else if (last) begin
                        n_done   = 1'b1;
                        n_status = lphtu_pkg::ST_FULL;
                        n_state  = B_IDLE;
                    end else begin
                        n_state = B_READ;
                    end
                end else begin
                    if (hit) begin
                        n_done  = 1'b1;
                        n_slot  = r_pos;
                        n_state = B_IDLE;
                        if (r_action == lphtu_pkg::ACT_ERASE) begin
                            we = 1'b1;
                            wd = {lphtu_pkg::TAG_DELETED, rkey};
                            if (r_used != '0) n_used = r_used - 1'b1;
                        end
                    end else if (tag == lphtu_pkg::TAG_EMPTY || last) begin
                        n_done   = 1'b1;
                        n_status = lphtu_pkg::ST_NOTFOUND;
                        n_state  = B_IDLE;
                    end else begin
                        n_state = B_READ;
                    end
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // slot memory, registered read
    always_ff @(posedge i_clk) begin
        if (we) mem[wa] <= wd;
        r_rdata <= mem[r_pos];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_SWEEP;
            r_sweep <= '0;
            r_reply <= 1'b0;
            r_used  <= '0;
            o_done  <= 1'b0;
        end else if (i_cfg_clear) begin
            r_state <= B_SWEEP;
            r_sweep <= '0;
            r_reply <= 1'b0;
            r_used  <= '0;
            o_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            o_done  <= n_done;
            if (r_state == B_SWEEP) r_sweep <= r_sweep + 1'b1;
            if (r_state == B_IDLE && i_valid) begin
                r_sweep <= '0;
                r_reply <= 1'b1;
            end
        end
        if (r_state == B_IDLE) begin
            r_action <= i_action;
            r_key    <= i_key;
            r_pos    <= i_home;
            r_n      <= '0;
        end else if (r_state == B_EVAL) begin
            r_pos <= n_pos;
            r_n   <= r_n + 1'b1;
        end
        o_status     <= n_status;
        o_slot_index <= n_slot;
        o_occupancy  <= n_used;
    end

    assign o_sweeping = (r_state == B_SWEEP);

endmodule

### hw/rtl/linear_probe_hash_table_unit.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit
// open addressing hash table with linear probing, search/insert/erase/clear
// ----------------------------------------------------------------------------
//  channel   signals                                  handshake
//  ------    ---------------------------------------  -------------------------
//  item in   start, i_action, i_key                   start & !busy
//  result    o_done, o_status, o_slot_index,          o_done, one cycle, no stall
//            o_occupancy
//  config    psel, penable, pwrite, paddr, pwdata,    setup + access, pready = 1
//            prdata, pready
//
//  the front runs each item through its bit-serial remainder unit (a clear
//  skips it); the back handles each probed slot as a registered memory read,
//  then a compare; a clear sweeps all TABLE_DEPTH slots, one a cycle, then
//  reports. after reset, and after each capacity write, a sweep of all
//  TABLE_DEPTH slots empties the slot memory while busy stays high. the result
//  receiver cannot stall: a two-entry queue lets the front take new items
//  while the back probes.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_unit #(
    parameter int KEY_BITS    = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // item channel
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_action,
    input  logic [KEY_BITS-1:0]          i_key,
    // result channel
    output logic                         o_done,
    output logic [1:0]                   o_status,
    output logic [lphtu_pkg::SLOT_W-1:0] o_slot_index,
    output logic [lphtu_pkg::CAP_W-1:0]  o_occupancy,
    // register port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    localparam int TABLE_DEPTH = lphtu_pkg::TABLE_DEPTH;
    localparam int SLOT_W      = lphtu_pkg::SLOT_W;
    localparam int CW          = lphtu_pkg::CAP_W;
    localparam int JOB_W       = 2 + KEY_BITS + SLOT_W;

    // capacity register, clamped to 1..TABLE_DEPTH where it is used
    logic [CW-1:0]      r_cap, cap_eff;
    logic               cfg_wr;
    lphtu_pkg::t_reg    reg_sel;

    // front to queue, queue to back
    logic               f_push, f_busy, q_full, q_valid, b_pop, b_sweep;
    lphtu_pkg::t_action f_action, b_action;
    logic [KEY_BITS-1:0] f_key, b_key;
    logic [SLOT_W-1:0]  f_home, b_home;
    logic [JOB_W-1:0]   q_out;
    lphtu_pkg::t_status b_status;

    assign pready  = 1'b1;
    // register index is the word address
    assign reg_sel = (paddr[2] == 1'b0) ? lphtu_pkg::REG_CAPACITY : lphtu_pkg::REG_NONE;
    assign cfg_wr  = psel && penable && pwrite && (reg_sel == lphtu_pkg::REG_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= lphtu_pkg::CAP_RESET;
        end else if (cfg_wr) begin
            r_cap <= pwdata[CW-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_sel)
            lphtu_pkg::REG_CAPACITY: prdata = {{(32 - CW){1'b0}}, r_cap};
            default:                 prdata = '0;
        endcase
    end

    // zero acts as one, anything above the depth acts as the depth
    always_comb begin
        if (r_cap == '0) begin
            cap_eff = CW'(1);
        end else if (int'(r_cap) > TABLE_DEPTH) begin
            cap_eff = CW'(TABLE_DEPTH);
        end else begin
            cap_eff = r_cap;
        end
    end

    // no item while the front is busy or the slot memory is being swept
    assign busy = f_busy || b_sweep;

    lphtu_front #(
        .KEY_BITS (KEY_BITS),
        .SLOT_W   (SLOT_W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (start && !busy),
        .i_action (lphtu_pkg::t_action'(i_action)),
        .i_key    (i_key),
        .i_cap    (cap_eff),
        .i_q_full (q_full),
        .o_push   (f_push),
        .o_action (f_action),
        .o_key    (f_key),
        .o_home   (f_home),
        .o_busy   (f_busy)
    );

    lphtu_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  ({f_action, f_key, f_home}),
        .i_pop   (b_pop),
        .o_data  (q_out),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    // unpack the queued job
    assign b_action = lphtu_pkg::t_action'(q_out[JOB_W-1 -: 2]);
    assign b_key    = q_out[SLOT_W +: KEY_BITS];
    assign b_home   = q_out[SLOT_W-1:0];

    lphtu_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS),
        .SLOT_W      (SLOT_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_clear  (cfg_wr),
        .i_cap        (cap_eff),
        .i_valid      (q_valid),
        .i_action     (b_action),
        .i_key        (b_key),
        .i_home       (b_home),
        .o_pop        (b_pop),
        .o_sweeping   (b_sweep),
        .o_done       (o_done),
        .o_status     (b_status),
        .o_slot_index (o_slot_index),
        .o_occupancy  (o_occupancy)
    );

    assign o_status = b_status;

endmodule
